[hw/rtl/assert_macros.svh]
// Assertion macros shared by the SHA-256 digest RTL.
// Included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NORST(lbl, clk, prop)
`endif
`endif

[hw/rtl/sha_pkg.sv]
// Package for the SHA-256 digest block: payload types and round constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_item;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic init;
    logic round;
    logic finish;
  } rnd_ctl_t;

  localparam logic [255:0] InitHash = {
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'h428A2F98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hB5C0FBCF;
      6'd3: k = 32'hE9B5DBA5; 6'd4: k = 32'h3956C25B; 6'd5: k = 32'h59F111F1;
      6'd6: k = 32'h923F82A4; 6'd7: k = 32'hAB1C5ED5; 6'd8: k = 32'hD807AA98;
      6'd9: k = 32'h12835B01; 6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
      6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE; 6'd14: k = 32'h9BDC06A7;
      6'd15: k = 32'hC19BF174; 6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
      6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC; 6'd20: k = 32'h2DE92C6F;
      6'd21: k = 32'h4A7484AA; 6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
      6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D; 6'd26: k = 32'hB00327C8;
      6'd27: k = 32'hBF597FC7; 6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
      6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27B70A85;
      6'd33: k = 32'h2E1B2138; 6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
      6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB; 6'd38: k = 32'h81C2C92E;
      6'd39: k = 32'h92722C85; 6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
      6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3; 6'd44: k = 32'hD192E819;
      6'd45: k = 32'hD6990624; 6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
      6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08; 6'd50: k = 32'h2748774C;
      6'd51: k = 32'h34B0BCB5; 6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
      6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3; 6'd56: k = 32'h748F82EE;
      6'd57: k = 32'h78A5636F; 6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
      6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB; 6'd62: k = 32'hBEF9A3F7;
      default: k = 32'hC67178F2;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/sha_round.sv]
// SHA-256 round unit: schedule window, working variables and hash words.
// One round per cycle under control of the sequencer. Uses sha_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sha_round (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sha_pkg::rnd_ctl_t   ctl_i,
  input  wire logic                rehash_i,
  input  wire logic [5:0]          round_i,
  input  wire logic [31:0]         msg_word_i,
  output logic [255:0]             hash_o
);

  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [31:0] w_new, t1, t2, e, a, s0, s1, p, r;

  // Next schedule word (message word for the first sixteen rounds) and round sums t1, t2.
  always_comb begin
    p = w_q[1];
    r = w_q[14];
    s0 = {p[6:0], p[31:7]} ^ {p[17:0], p[31:18]} ^ (p >> 3);
    s1 = {r[16:0], r[31:17]} ^ {r[18:0], r[31:19]} ^ (r >> 10);
    w_new = (round_i < 6'd16) ? msg_word_i : (w_q[0] + s0 + w_q[9] + s1);
    e = v_q[4];
    a = v_q[0];
    t1 = v_q[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
       + ((e & v_q[5]) ^ (~e & v_q[6])) + sha_pkg::round_k(round_i) + w_new;
    t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
       + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // Schedule window shifts by one word per round.
  always_ff @(posedge clk_i) begin
    if (ctl_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
    end
  end

  // Working variables.
  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (ctl_i.round) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  // Hash words: accumulate after a block, restore after a digest.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitHash[255-32*i -: 32];
    end else if (rehash_i) begin
      for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitHash[255-32*i -: 32];
    end else if (ctl_i.finish) begin
      for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) hash_o[255-32*i -: 32] = h_q[i];
  end

  `ASSERT_IMPL(a_ctl_onehot, clk_i, rst_ni, $onehot0({ctl_i.init, ctl_i.round, ctl_i.finish}))
  `ASSERT_IMPL(a_no_rehash_mid, clk_i, rst_ni, rehash_i |-> !ctl_i.finish)
  `ASSERT_IMPL(a_finish_last, clk_i, rst_ni, ctl_i.finish |-> $past(ctl_i.round))

endmodule
`default_nettype wire

[hw/rtl/sha256_message_digest.sv]
// Top level of the SHA-256 digest: byte gathering, padding sequencer, output.
// Uses sha_pkg, sha_round and assert_macros.svh.
//
// Usage: a request on the input channel carries one message byte (when
// byte_valid is set) and a last_item flag. Bytes are buffered into a
// 64-byte block register. A byte that completes a block starts compression
// (a load, 64 rounds through the single shared round unit, a hash update);
// the input stalls meanwhile. Ordinary bytes are taken one per cycle while
// no compression stalls the input.
// On last_item the sequencer writes the pad byte, zero fill and the bit
// length one byte per cycle and runs one or two more compressions, then puts
// the eight digest words on the output channel, word 0 first, last_word on
// word 7. The input stays stalled until the eighth word is taken. The hash
// then returns to its initial values.
// A stalled output request holds its payload; the block waits for it.
// Reset clears counters and restores the initial hash; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sha256_message_digest (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire sha_pkg::sha_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output sha_pkg::sha_out_t      out_data_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StInit  = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StFin   = 3'd3;
  localparam logic [2:0] StPad   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]  st_q, st_d;
  logic [31:0] blk_q [16];
  logic [5:0]  fill_q;
  logic [60:0] total_q;
  logic [5:0]  rnd_q;
  logic        padding_q;   // in end-of-message padding
  logic        lenblk_q;    // current padding block carries the length
  logic        pad80_q;
  logic        lenok_q;
  logic [2:0]  oidx_q;
  logic [255:0] hash;
  logic        acc;
  logic [63:0] bits;
  logic [3:0]  wsel;
  logic [31:0] msg_word;
  sha_pkg::rnd_ctl_t ctl;
  logic        rehash;

  assign acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != StIdle);
  assign bits = {total_q, 3'b000};
  assign wsel = rnd_q[3:0];
  assign msg_word = blk_q[wsel];

  assign ctl.init = (st_q == StInit);
  assign ctl.round = (st_q == StRound);
  assign ctl.finish = (st_q == StFin);
  assign rehash = (st_q == StOut) && !out_stall_i && (oidx_q == 3'd7);

  sha_round u_round (
    .clk_i, .rst_ni, .ctl_i(ctl), .rehash_i(rehash),
    .round_i(rnd_q), .msg_word_i(msg_word), .hash_o(hash)
  );

  // Sequencer and byte buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; fill_q <= '0; total_q <= '0; rnd_q <= '0;
      padding_q <= 1'b0; lenblk_q <= 1'b0; oidx_q <= '0;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        StIdle: begin
          if (acc && in_data_i.byte_valid) begin
            fill_q <= fill_q + 6'd1;
            total_q <= total_q + 61'd1;
          end
          if (acc && in_data_i.last_item) padding_q <= 1'b1;
        end
        StInit: rnd_q <= '0;
        StRound: rnd_q <= rnd_q + 6'd1;
        StFin: begin
          fill_q <= '0;
          if (padding_q && lenblk_q) begin
            padding_q <= 1'b0;
            lenblk_q <= 1'b0;
            oidx_q <= '0;
          end
        end
        StPad: begin
          // First pad step writes 0x80; the rest write zeros or the length.
          fill_q <= fill_q + 6'd1;
          if (fill_q == 6'd63) lenblk_q <= pad80_q && lenok_q;
        end
        StOut: begin
          if (!out_stall_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) total_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Pad marker: 0x80 written once per message.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad80_q <= 1'b0;
    end else if (st_q == StIdle && acc && in_data_i.last_item) begin
      pad80_q <= 1'b0;
    end else if (st_q == StPad) begin
      if (!pad80_q) pad80_q <= 1'b1;
    end
  end

  // Length decision: at the first pad step, set if padding starts below byte 56;
  // set again after each compression, so a second pad block carries the length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lenok_q <= 1'b0;
    end else if (st_q == StPad && !pad80_q) begin
      lenok_q <= (fill_q < sha_pkg::LenStart);
    end else if (st_q == StFin) begin
      lenok_q <= 1'b1;
    end
  end

  // Block byte writes into big-endian byte lanes of the word buffer.
  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && acc && in_data_i.byte_valid) begin
      blk_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= in_data_i.data_byte;
    end else if (st_q == StPad) begin
      if (!pad80_q) begin
        blk_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= sha_pkg::PadByte;
      end else if (lenok_q && fill_q >= sha_pkg::LenStart) begin
        blk_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <=
          bits[8*(63 - 32'(fill_q)) +: 8];
      end else begin
        blk_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= 8'h00;
      end
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: begin
        if (acc) begin
          if (in_data_i.byte_valid && fill_q == 6'd63) st_d = StInit;
          else if (in_data_i.last_item) st_d = StPad;
        end
      end
      StInit: st_d = StRound;
      StRound: if (rnd_q == 6'd63) st_d = StFin;
      StFin: begin
        if (padding_q && lenblk_q) st_d = StOut;
        else if (padding_q) st_d = StPad;
        else st_d = StIdle;
      end
      StPad: if (fill_q == 6'd63) st_d = StInit;
      StOut: if (!out_stall_i && oidx_q == 3'd7) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_o = (st_q == StOut);
    out_data_o.digest_word = hash[255 - 32*oidx_q -: 32];
    out_data_o.word_index = oidx_q;
    out_data_o.last_word = (oidx_q == 3'd7);
  end

  `ASSERT_IMPL(a_stall_busy, clk_i, rst_ni, (st_q == StRound) |-> in_stall_o)
  `ASSERT_IMPL(a_out_only, clk_i, rst_ni, out_valid_o |-> !padding_q)
  `ASSERT_IMPL(a_len_before_out, clk_i, rst_ni, $rose(out_valid_o) |-> $past(st_q == StFin))

endmodule
`default_nettype wire
